/* hdl/mpeg_audio_frame_header_parser_top_defines.svh */
// ----------------------------------------------------------------------------
// mpeg audio frame header parser: assertion macros
// shared property forms for the concurrent checks of the parser
// ----------------------------------------------------------------------------
`ifndef MPEG_AUDIO_FRAME_HEADER_PARSER_TOP_DEFINES_SVH
`define MPEG_AUDIO_FRAME_HEADER_PARSER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define MAFHP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define MAFHP_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/mafhp_pkg.sv */
// ----------------------------------------------------------------------------
// mafhp_pkg
// types, tables and constants shared by the frame header parser modules
// ----------------------------------------------------------------------------
package mafhp_pkg;

   // field widths
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned SIZE_W    = 12;
   localparam int unsigned SMP_W     = 12;
   localparam int unsigned POS_W     = 6;
   localparam int unsigned SIDE_W    = 6;
   localparam int unsigned PROD_W    = 16;
   localparam int unsigned NUM_W     = 26;
   localparam int unsigned DEN_W     = 16;
   localparam int unsigned QUO_W     = 12;
   localparam int unsigned DIV_CNT_W = 4;

   // header check masks and patterns
   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [7:0] SYNC_MASK   = 8'hE0;
   localparam logic [7:0] VER_MASK    = 8'h18;
   localparam logic [7:0] VER_RSVD    = 8'h08;
   localparam logic [7:0] LAYER_MASK  = 8'h06;
   localparam logic [7:0] RATE_MASK   = 8'h0C;
   localparam logic [7:0] BRATE_MASK  = 8'hF0;
   localparam logic [1:0] VER_MPEG1   = 2'd3;
   localparam logic [1:0] MODE_MONO   = 2'd3;
   localparam logic [1:0] LAYER_CLAMP = 2'd2;
   localparam logic [1:0] LAYER_ONE   = 2'd0;

   // byte positions within an attempt
   localparam logic [POS_W-1:0] POS_FIRST    = 6'd1;
   localparam logic [POS_W-1:0] POS_SECOND   = 6'd2;
   localparam logic [POS_W-1:0] POS_HDR_LAST = 6'd3;
   localparam logic [POS_W-1:0] POS_BODY     = 6'd4;
   localparam logic [POS_W-1:0] SKIP_BYTES   = 6'd2;
   localparam logic [1:0]       TAG_LAST_J   = 2'd3;
   localparam logic [SIZE_W-1:0] TAG_SPAN    = 12'd8;

   // kbit to bit scale
   localparam int unsigned KBPS_SCALE = 1000;

   // tag strings, first character in the top byte
   localparam logic [31:0] TAG_INFO = 32'h496E666F;
   localparam logic [31:0] TAG_ALT  = 32'h58696E67;

   // bitrate in kbit/s, by version group, layer and bitrate code
   localparam logic [8:0] KBPS_TAB [0:1][0:2][0:15] = '{
      '{ '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
           9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
         '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
           9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0} },
      '{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0} }
   };

   // sample rate in Hz, by version code and rate code
   localparam logic [DEN_W-1:0] RATE_TAB [0:3][0:3] = '{
      '{16'd11025, 16'd12000, 16'd8000,  16'd0},
      '{16'd0,     16'd0,     16'd0,     16'd0},
      '{16'd22050, 16'd24000, 16'd16000, 16'd0},
      '{16'd44100, 16'd48000, 16'd32000, 16'd0}
   };

   // length coefficient by version group and layer
   localparam logic [7:0] COEF_TAB [0:1][0:2] = '{
      '{8'd12, 8'd144, 8'd144},
      '{8'd12, 8'd144, 8'd72}
   };

   // samples per frame by version group and layer
   localparam logic [SMP_W-1:0] SPF_TAB [0:1][0:2] = '{
      '{12'd384, 12'd1152, 12'd1152},
      '{12'd384, 12'd1152, 12'd576}
   };

   // side info length by version group and stereo flag
   localparam logic [SIDE_W-1:0] SIDE_TAB [0:1][0:1] = '{
      '{6'd17, 6'd32},
      '{6'd9,  6'd17}
   };

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_MULT,
      ST_DIV,
      ST_SIZE,
      ST_BODY
   } state_type;

   // kind of result loaded into the output register
   typedef enum logic [1:0] {
      RES_INVALID,
      RES_NOTAG,
      RES_TAG
   } res_type;

   // commands from controller to datapath
   typedef struct packed {
      logic    start;
      logic    hdr_byte;
      logic    hdr_last;
      logic    div_go;
      logic    size_load;
      logic    body_step;
      logic    res_load;
      res_type res_kind;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic frame_start;
      logic byte_zero;
      logic hdr_last;
      logic hdr_ok;
      logic free_fmt;
      logic div_done;
      logic too_short;
      logic skip_zone;
      logic side_zone;
      logic tag_last;
   } sts_type;

   // one character of a tag string
   function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] j);
      logic [7:0] b;
      case (j)
         2'd0:    b = tag[31:24];
         2'd1:    b = tag[23:16];
         2'd2:    b = tag[15:8];
         default: b = tag[7:0];
      endcase
      return b;
   endfunction

endpackage

/* hdl/mafhp_div.sv */
// ----------------------------------------------------------------------------
// mafhp_div
// restoring divider, one quotient bit per cycle, for the frame length
// ----------------------------------------------------------------------------
module mafhp_div
   import mafhp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quo
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]       rem_ff, rem_in;
   logic [NUM_W:0]         dsh_ff, dsh_in;
   logic [QUO_W-1:0]       quo_ff, quo_in;
   logic [NUM_W:0]         diff;
   logic                   fits;

   // trial subtraction of the shifted divisor
   always_comb begin
      fits = {1'b0, rem_ff} >= dsh_ff;
      diff = {1'b0, rem_ff} - dsh_ff;
   end

   // step control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // remainder, divisor and quotient
   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (start) begin
         rem_in = num;
         dsh_in = {den, (QUO_W - 1)'(0)};
         quo_in = '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff[NUM_W-1:0];
         end
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* hdl/mafhp_dp.sv */
// ----------------------------------------------------------------------------
// mafhp_dp
// datapath: header capture, table lookup, length arithmetic, side info and
// tag matching, result register
// ----------------------------------------------------------------------------
module mafhp_dp
   import mafhp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              frame_start,
   input  cmd_type           cmd,
   output sts_type           sts,
   output logic              header_valid,
   output logic [SIZE_W-1:0] frame_bytes,
   output logic [SMP_W-1:0]  sample_count,
   output logic              tag_found
);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [1:0]        flags_ff, flags_in;
   logic [23:0]       hdr_ff, hdr_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DEN_W-1:0]  rate_ff, rate_in;
   logic              pad_ff, pad_in;
   logic              layer1_ff, layer1_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SMP_W-1:0]  smp_ff, smp_in;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic              res_valid_ff, res_valid_in;
   logic [SIZE_W-1:0] res_size_ff, res_size_in;
   logic [SMP_W-1:0]  res_smp_ff, res_smp_in;
   logic              res_tag_ff, res_tag_in;

   logic [7:0]        h0, h1, h2;
   logic [1:0]        ver, lcode, layer, src;
   logic [3:0]        brc;
   logic              grp, stereo, hdr_ok;
   logic [7:0]        coef;
   logic [8:0]        kbps;
   logic [16:0]       prod_full;
   logic [SMP_W-1:0]  spf;
   logic [NUM_W-1:0]  num;
   logic              div_done;
   logic [QUO_W-1:0]  quo;
   logic [SIZE_W-1:0] qsum, size_div;
   logic [POS_W-1:0]  body_idx, tag_j;
   logic              skip_zone, side_zone;
   logic [1:0]        flags_next;

   // header decode from the three saved bytes and the current byte
   always_comb begin
      h0        = hdr_ff[23:16];
      h1        = hdr_ff[15:8];
      h2        = hdr_ff[7:0];
      hdr_ok    = (h0 == SYNC_BYTE) && ((h1 & SYNC_MASK) == SYNC_MASK) &&
                  ((h1 & VER_MASK) != VER_RSVD) && ((h1 & LAYER_MASK) != 8'h00) &&
                  ((h2 & RATE_MASK) != RATE_MASK) && ((h2 & BRATE_MASK) != BRATE_MASK);
      ver       = h1[4:3];
      grp       = (ver != VER_MPEG1);
      lcode     = 2'd3 - h1[2:1];
      layer     = (lcode > LAYER_CLAMP) ? LAYER_CLAMP : lcode;
      brc       = h2[7:4];
      src       = h2[3:2];
      stereo    = (data_byte[7:6] != MODE_MONO);
      coef      = COEF_TAB[grp][layer];
      kbps      = KBPS_TAB[grp][layer][brc];
      prod_full = 17'(coef) * 17'(kbps);
      spf       = SPF_TAB[grp][layer];
   end

   // scaled numerator feeds the divider load directly
   assign num = NUM_W'(prod_ff) * NUM_W'(KBPS_SCALE);

   mafhp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .num   (num),
      .den   (rate_ff),
      .done  (div_done),
      .quo   (quo)
   );

   // length from quotient, padding and slot size
   always_comb begin
      qsum     = quo + SIZE_W'(pad_ff);
      size_div = layer1_ff ? {qsum[SIZE_W-3:0], 2'b00} : qsum;
   end

   // zones of the bytes after the header
   always_comb begin
      body_idx   = pos_ff - POS_BODY;
      tag_j      = body_idx - side_ff;
      skip_zone  = body_idx < SKIP_BYTES;
      side_zone  = body_idx < side_ff;
      flags_next = {flags_ff[1] & (data_byte == tag_byte(TAG_ALT, tag_j[1:0])),
                    flags_ff[0] & (data_byte == tag_byte(TAG_INFO, tag_j[1:0]))};
   end

   // position, header bytes and tag flags
   always_comb begin
      pos_in   = pos_ff;
      flags_in = flags_ff;
      hdr_in   = hdr_ff;
      if (cmd.start) begin
         hdr_in   = {data_byte, 16'h0000};
         pos_in   = POS_FIRST;
         flags_in = 2'b11;
      end else if (cmd.hdr_byte) begin
         if (pos_ff == POS_FIRST) begin
            hdr_in[15:8] = data_byte;
         end else if (pos_ff == POS_SECOND) begin
            hdr_in[7:0] = data_byte;
         end
         pos_in = pos_ff + 1'b1;
      end else if (cmd.hdr_last) begin
         pos_in = POS_BODY;
      end else if (cmd.body_step) begin
         pos_in = pos_ff + 1'b1;
         if (!skip_zone && !side_zone) begin
            flags_in = flags_next;
         end
      end
   end

   // frame parameters latched at the last header byte
   always_comb begin
      prod_in   = prod_ff;
      rate_in   = rate_ff;
      pad_in    = pad_ff;
      layer1_in = layer1_ff;
      size_in   = size_ff;
      smp_in    = smp_ff;
      side_in   = side_ff;
      if (cmd.hdr_last) begin
         prod_in   = prod_full[PROD_W-1:0];
         rate_in   = RATE_TAB[ver][src];
         pad_in    = h2[1];
         layer1_in = (layer == LAYER_ONE);
         size_in   = '0;
         smp_in    = stereo ? {spf[SMP_W-2:0], 1'b0} : spf;
         side_in   = SIDE_TAB[grp][stereo];
      end else if (cmd.size_load) begin
         size_in = size_div;
      end
   end

   // result register
   always_comb begin
      res_valid_in = res_valid_ff;
      res_size_in  = res_size_ff;
      res_smp_in   = res_smp_ff;
      res_tag_in   = res_tag_ff;
      if (cmd.res_load) begin
         case (cmd.res_kind)
            RES_INVALID: begin
               res_valid_in = 1'b0;
               res_size_in  = '0;
               res_smp_in   = '0;
               res_tag_in   = 1'b0;
            end
            RES_TAG: begin
               res_valid_in = 1'b1;
               res_size_in  = size_ff;
               res_smp_in   = smp_ff;
               res_tag_in   = |flags_next;
            end
            default: begin
               res_valid_in = 1'b1;
               res_size_in  = size_ff;
               res_smp_in   = smp_ff;
               res_tag_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         flags_ff <= 2'b11;
      end else begin
         pos_ff   <= pos_in;
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff       <= hdr_in;
      prod_ff      <= prod_in;
      rate_ff      <= rate_in;
      pad_ff       <= pad_in;
      layer1_ff    <= layer1_in;
      size_ff      <= size_in;
      smp_ff       <= smp_in;
      side_ff      <= side_in;
      res_valid_ff <= res_valid_in;
      res_size_ff  <= res_size_in;
      res_smp_ff   <= res_smp_in;
      res_tag_ff   <= res_tag_in;
   end

   // status towards the controller
   always_comb begin
      sts.frame_start = frame_start;
      sts.byte_zero   = (data_byte == 8'h00);
      sts.hdr_last    = (pos_ff == POS_HDR_LAST);
      sts.hdr_ok      = hdr_ok;
      sts.free_fmt    = (brc == 4'h0);
      sts.div_done    = div_done;
      sts.too_short   = size_ff < (SIZE_W'(side_ff) + TAG_SPAN);
      sts.skip_zone   = skip_zone;
      sts.side_zone   = side_zone;
      sts.tag_last    = (tag_j[1:0] == TAG_LAST_J);
   end

   assign header_valid = res_valid_ff;
   assign frame_bytes  = res_size_ff;
   assign sample_count = res_smp_ff;
   assign tag_found    = res_tag_ff;

endmodule

/* hdl/mafhp_ctrl.sv */
// ----------------------------------------------------------------------------
// mafhp_ctrl
// controller: walks each frame attempt, sequences the length division and
// owns both channel handshakes
// ----------------------------------------------------------------------------
`include "mpeg_audio_frame_header_parser_top_defines.svh"

module mafhp_ctrl
   import mafhp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // input is taken only in byte-consuming states with the output free
   assign req_tready = !rsp_valid_ff &&
                       ((state_ff == ST_IDLE) || (state_ff == ST_HDR) ||
                        (state_ff == ST_BODY));
   assign accept     = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.res_kind = RES_NOTAG;
      case (state_ff)
         ST_IDLE: begin
            if (accept && sts.frame_start) begin
               cmd.start = 1'b1;
               state_in  = ST_HDR;
            end
         end
         ST_HDR: begin
            if (accept) begin
               if (sts.frame_start) begin
                  cmd.start = 1'b1;
               end else if (sts.hdr_last) begin
                  cmd.hdr_last = 1'b1;
                  if (!sts.hdr_ok) begin
                     cmd.res_load = 1'b1;
                     cmd.res_kind = RES_INVALID;
                     state_in     = ST_IDLE;
                  end else if (sts.free_fmt) begin
                     state_in = ST_SIZE;
                  end else begin
                     state_in = ST_MULT;
                  end
               end else begin
                  cmd.hdr_byte = 1'b1;
               end
            end
         end
         ST_MULT: begin
            cmd.div_go = 1'b1;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.size_load = 1'b1;
               state_in      = ST_SIZE;
            end
         end
         ST_SIZE: begin
            if (sts.too_short) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            if (accept) begin
               if (sts.frame_start) begin
                  cmd.start = 1'b1;
                  state_in  = ST_HDR;
               end else begin
                  cmd.body_step = 1'b1;
                  if (sts.skip_zone) begin
                     state_in = ST_BODY;
                  end else if (sts.side_zone) begin
                     if (!sts.byte_zero) begin
                        cmd.res_load = 1'b1;
                        state_in     = ST_IDLE;
                     end
                  end else if (sts.tag_last) begin
                     cmd.res_load = 1'b1;
                     cmd.res_kind = RES_TAG;
                     state_in     = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output transaction pending flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // checks
   `MAFHP_ASSERT_IMP(a_no_result_overwrite, clock, reset, cmd.res_load, !rsp_valid_ff, "result overwritten before taken")
   `MAFHP_ASSERT_IMP(a_div_done_in_wait, clock, reset, sts.div_done, state_ff == ST_DIV, "divider finished outside the wait state")
   `MAFHP_ASSERT_NXT(a_mult_starts_div, clock, reset, state_ff == ST_MULT, state_ff == ST_DIV && !sts.div_done, "division not under way after start")
   `MAFHP_ASSERT_NXT(a_load_raises_valid, clock, reset, cmd.res_load, rsp_valid_ff, "loaded result not offered")

endmodule

/* hdl/mpeg_audio_frame_header_parser_top.sv */
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_parser_top
// MPEG audio frame header parser: header check, frame length, sample count
// and detection of an Info-style tag behind zeroed side info
// ----------------------------------------------------------------------------
// Usage: stream bytes arrive on the req_ channel, one per transaction, with
// req_tuser set on the first byte of a candidate frame. Each finished
// attempt gives one transaction on the rsp_ channel; a new start mark drops
// an attempt in progress without a result, and bytes outside an attempt are
// consumed and ignored.
// Throughput: one byte per cycle, except after the fourth header byte of a
// legal header, where req_tready stays low while the length is worked out:
// for a nonzero bitrate code the divider is started and runs 12 restoring
// steps of one quotient bit each and the length is taken, then the length is
// checked against side info and tag span.
// Result: the result appears in the cycle after the byte that ends the
// attempt, or, when a free-format header or a computed length too short to
// hold a tag ends it, in the cycle after the length check state.
// Stall: one result register sits on the output; while it holds an untaken
// result, req_tready is low. Reset (synchronous, active high) returns the
// controller to idle and drops any pending result; the result data is not cleared.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_header_parser_top
   import mafhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [11:0] frame_bytes, [23:12] sample_count
   output logic [1:0]  rsp_tuser    // [0] header_valid, [1] tag_found
);

   cmd_type           cmd;
   sts_type           sts;
   logic              header_valid;
   logic [SIZE_W-1:0] frame_bytes;
   logic [SMP_W-1:0]  sample_count;
   logic              tag_found;

   // sequencing and handshakes
   mafhp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // header decode, arithmetic and result storage
   mafhp_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .data_byte    (req_tdata),
      .frame_start  (req_tuser),
      .cmd          (cmd),
      .sts          (sts),
      .header_valid (header_valid),
      .frame_bytes  (frame_bytes),
      .sample_count (sample_count),
      .tag_found    (tag_found)
   );

   // result packing
   assign rsp_tdata = {sample_count, frame_bytes};
   assign rsp_tuser = {tag_found, header_valid};

endmodule
